// File: src/sopg_pkg.sv
package sopg_pkg;

   // internal signed coordinate width: covers anchor/cursor range and spans up to 32767
   localparam int CW = 18;
   localparam int PIX_W = 13;
   localparam int SIZE_W = 14;
   localparam int POS_W = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 15;
   localparam int COLOR_W = 32;

   localparam int MAX_WIDTH_DEF = 8192;
   localparam int MAX_HEIGHT_DEF = 8192;

   localparam logic [COLOR_W-1:0] COLOR_DIM   = 32'haa00_0000;
   localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hffff_ffff;
   localparam logic [COLOR_W-1:0] COLOR_CLEAR = 32'h0000_0000;

   localparam int ARM_REACH = 10;

   typedef logic signed [CW-1:0] coord_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SURFACE_W  = 3'd0,
      CSR_SURFACE_H  = 3'd1,
      CSR_ANCHOR_COL = 3'd2,
      CSR_ANCHOR_ROW = 3'd3,
      CSR_CURSOR_COL = 3'd4,
      CSR_CURSOR_ROW = 3'd5,
      CSR_DRAG       = 3'd6
   } csr_index_type;

   // per-axis geometry derived from the configuration
   typedef struct packed {
      coord_type lim;       // effective surface size
      coord_type org;       // clamped rectangle origin
      coord_type fin;       // origin plus clamped length (exclusive end)
      logic      nonempty;  // clamped length above zero
      coord_type lo0;       // outer ring, low edge
      coord_type hi0;       // outer ring, high edge
      coord_type lo1;       // inner ring, low edge
      coord_type hi1;       // inner ring, high edge
      coord_type cc;        // clamped cursor
      coord_type cc_lo;     // crosshair arm start
      coord_type cc_hi;     // crosshair arm end
   } axis_geo_type;

   // pixel lies on one border ring
   function automatic logic ring_hit(input coord_type c, input coord_type r,
                                     input coord_type lo_c, input coord_type hi_c,
                                     input coord_type lo_r, input coord_type hi_r);
      logic row_side;
      logic col_side;
      row_side = (r == lo_r || r == hi_r) && c >= lo_c && c <= hi_c;
      col_side = (c == lo_c || c == hi_c) && r >= lo_r && r <= hi_r;
      return row_side || col_side;
   endfunction

endpackage

// File: src/sopg_axis.sv
// Geometry of one axis: effective size, clamped span, border rings and
// crosshair limits. Free-running four-stage pipeline on the configuration.
module sopg_axis
   import sopg_pkg::*;
#(
   parameter int MAX_SIZE = MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic [SIZE_W-1:0]        size,
   input  logic signed [POS_W-1:0]  anchor,
   input  logic signed [POS_W-1:0]  cursor,
   output axis_geo_type             geo
);

   localparam coord_type ONE = coord_type'(1);
   localparam coord_type TWO = coord_type'(2);
   localparam coord_type ZERO = coord_type'(0);
   localparam coord_type MAXV = coord_type'(MAX_SIZE);
   localparam coord_type REACH = coord_type'(ARM_REACH);

   coord_type size_ext;
   coord_type anchor_ext;
   coord_type cursor_ext;

   // stage 1: effective size, normalized span
   coord_type lim1_in, lim1_ff;
   coord_type org1_in, org1_ff;
   coord_type len1_in, len1_ff;
   coord_type cur1_ff;
   // stage 2: clamped origin and cursor
   coord_type lim2_ff;
   coord_type org2_in, org2_ff;
   coord_type len2_ff;
   coord_type cc2_in, cc2_ff;
   // stage 3: clamped length
   coord_type lim3_ff;
   coord_type org3_ff;
   coord_type len3_in, len3_ff;
   coord_type cc3_ff;
   // stage 4: rings and arms
   axis_geo_type geo_in, geo_ff;

   assign size_ext   = $signed(CW'(size));
   assign anchor_ext = CW'(anchor);
   assign cursor_ext = CW'(cursor);

   always_comb begin
      if (size_ext < ONE) begin
         lim1_in = ONE;
      end else if (size_ext > MAXV) begin
         lim1_in = MAXV;
      end else begin
         lim1_in = size_ext;
      end
      if (cursor_ext < anchor_ext) begin
         org1_in = cursor_ext;
         len1_in = anchor_ext - cursor_ext;
      end else begin
         org1_in = anchor_ext;
         len1_in = cursor_ext - anchor_ext;
      end
   end

   always_comb begin
      if (org1_ff < ZERO) begin
         org2_in = ZERO;
      end else if (org1_ff > lim1_ff) begin
         org2_in = lim1_ff;
      end else begin
         org2_in = org1_ff;
      end
      if (cur1_ff < ZERO) begin
         cc2_in = ZERO;
      end else if (cur1_ff > lim1_ff - ONE) begin
         cc2_in = lim1_ff - ONE;
      end else begin
         cc2_in = cur1_ff;
      end
   end

   // length is never negative here, only the upper clamp matters
   always_comb begin
      if (len2_ff > lim2_ff - org2_ff) begin
         len3_in = lim2_ff - org2_ff;
      end else begin
         len3_in = len2_ff;
      end
   end

   // origin >= 0 and end <= size, so each ring edge needs one clamp only
   always_comb begin
      coord_type fin;
      coord_type last;
      fin  = org3_ff + len3_ff;
      last = lim3_ff - ONE;
      geo_in.lim      = lim3_ff;
      geo_in.org      = org3_ff;
      geo_in.fin      = fin;
      geo_in.nonempty = len3_ff > ZERO;
      geo_in.lo0      = (org3_ff > last) ? last : org3_ff;
      geo_in.lo1      = (org3_ff + ONE > last) ? last : org3_ff + ONE;
      geo_in.hi0      = (fin - ONE < ZERO) ? ZERO : fin - ONE;
      geo_in.hi1      = (fin - TWO < ZERO) ? ZERO : fin - TWO;
      geo_in.cc       = cc3_ff;
      geo_in.cc_lo    = cc3_ff - REACH;
      geo_in.cc_hi    = cc3_ff + REACH;
   end

   always_ff @(posedge clock) begin
      lim1_ff <= lim1_in;
      org1_ff <= org1_in;
      len1_ff <= len1_in;
      cur1_ff <= cursor_ext;
      lim2_ff <= lim1_ff;
      org2_ff <= org2_in;
      len2_ff <= len1_ff;
      cc2_ff  <= cc2_in;
      lim3_ff <= lim2_ff;
      org3_ff <= org2_ff;
      len3_ff <= len3_in;
      cc3_ff  <= cc2_ff;
      geo_ff  <= geo_in;
   end

   assign geo = geo_ff;

endmodule

// File: src/selection_overlay_pixel_generator.sv
// Selection overlay pixel generator: one ARGB8888 color per pixel request.
// A request (start high while busy is low) is taken every clock cycle; busy
// stays low. Each request yields exactly one result, strobed by rsp_valid
// for one cycle, in request order. The receiver cannot stall, so results
// are never held. Each request's coordinates wait out the four-stage
// geometry pipeline per axis, then pass a compare stage and a color stage.
// Configuration may be written only while no request is in flight; a
// request may follow a write in the very next cycle.
module selection_overlay_pixel_generator
   import sopg_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [PIX_W-1:0]       req_pixel_col,
   input  logic [PIX_W-1:0]       req_pixel_row,
   output logic                   rsp_valid,
   output logic [COLOR_W-1:0]     rsp_argb_color,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PIX_STAGES = 4;
   localparam int VLD_STAGES = 6;

   // configuration registers
   logic [SIZE_W-1:0]       surface_w_ff, surface_w_in;
   logic [SIZE_W-1:0]       surface_h_ff, surface_h_in;
   logic signed [POS_W-1:0] anchor_col_ff, anchor_col_in;
   logic signed [POS_W-1:0] anchor_row_ff, anchor_row_in;
   logic signed [POS_W-1:0] cursor_col_ff, cursor_col_in;
   logic signed [POS_W-1:0] cursor_row_ff, cursor_row_in;
   logic                    drag_ff, drag_in;

   axis_geo_type geo_col;
   axis_geo_type geo_row;

   logic [VLD_STAGES-1:0] vld_ff, vld_in;
   logic [PIX_W-1:0]      col_ff [PIX_STAGES];
   logic [PIX_W-1:0]      row_ff [PIX_STAGES];

   logic outside_ff, outside_in;
   logic white_ff, white_in;
   logic clear_ff, clear_in;
   logic [COLOR_W-1:0] color_ff, color_in;

   assign busy = 1'b0;

   // register writes
   always_comb begin
      surface_w_in  = surface_w_ff;
      surface_h_in  = surface_h_ff;
      anchor_col_in = anchor_col_ff;
      anchor_row_in = anchor_row_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      drag_in       = drag_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SURFACE_W:  surface_w_in  = csr_wdata[SIZE_W-1:0];
            CSR_SURFACE_H:  surface_h_in  = csr_wdata[SIZE_W-1:0];
            CSR_ANCHOR_COL: anchor_col_in = $signed(csr_wdata[POS_W-1:0]);
            CSR_ANCHOR_ROW: anchor_row_in = $signed(csr_wdata[POS_W-1:0]);
            CSR_CURSOR_COL: cursor_col_in = $signed(csr_wdata[POS_W-1:0]);
            CSR_CURSOR_ROW: cursor_row_in = $signed(csr_wdata[POS_W-1:0]);
            CSR_DRAG:       drag_in       = csr_wdata[0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_w_ff  <= SIZE_W'(1920);
         surface_h_ff  <= SIZE_W'(1080);
         anchor_col_ff <= '0;
         anchor_row_ff <= '0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         drag_ff       <= 1'b0;
      end else begin
         surface_w_ff  <= surface_w_in;
         surface_h_ff  <= surface_h_in;
         anchor_col_ff <= anchor_col_in;
         anchor_row_ff <= anchor_row_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         drag_ff       <= drag_in;
      end
   end

   // geometry per axis, aligned with the pixel pipeline
   sopg_axis #(.MAX_SIZE(MAX_WIDTH)) u_axis_col (
      .clock  (clock),
      .size   (surface_w_ff),
      .anchor (anchor_col_ff),
      .cursor (cursor_col_ff),
      .geo    (geo_col)
   );

   sopg_axis #(.MAX_SIZE(MAX_HEIGHT)) u_axis_row (
      .clock  (clock),
      .size   (surface_h_ff),
      .anchor (anchor_row_ff),
      .cursor (cursor_row_ff),
      .geo    (geo_row)
   );

   // valid bits
   assign vld_in = {vld_ff[VLD_STAGES-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // pixel coordinates wait for the geometry
   always_ff @(posedge clock) begin
      col_ff[0] <= req_pixel_col;
      row_ff[0] <= req_pixel_row;
      for (int i = 1; i < PIX_STAGES; i++) begin
         col_ff[i] <= col_ff[i-1];
         row_ff[i] <= row_ff[i-1];
      end
   end

   // compare stage
   always_comb begin
      coord_type c;
      coord_type r;
      logic in_rect;
      logic border;
      logic on_cross;
      c = $signed(CW'(col_ff[PIX_STAGES-1]));
      r = $signed(CW'(row_ff[PIX_STAGES-1]));
      outside_in = (c >= geo_col.lim) || (r >= geo_row.lim);
      in_rect = (c >= geo_col.org) && (c < geo_col.fin) &&
                (r >= geo_row.org) && (r < geo_row.fin);
      border = geo_col.nonempty && geo_row.nonempty &&
               (ring_hit(c, r, geo_col.lo0, geo_col.hi0, geo_row.lo0, geo_row.hi0) ||
                ring_hit(c, r, geo_col.lo1, geo_col.hi1, geo_row.lo1, geo_row.hi1));
      on_cross = ((r == geo_row.cc) && (c >= geo_col.cc_lo) && (c <= geo_col.cc_hi)) ||
                 ((c == geo_col.cc) && (r >= geo_row.cc_lo) && (r <= geo_row.cc_hi));
      white_in = on_cross || (drag_ff && border);
      clear_in = drag_ff && in_rect;
   end

   always_ff @(posedge clock) begin
      outside_ff <= outside_in;
      white_ff   <= white_in;
      clear_ff   <= clear_in;
   end

   // color stage
   always_comb begin
      if (outside_ff) begin
         color_in = COLOR_DIM;
      end else if (white_ff) begin
         color_in = COLOR_WHITE;
      end else if (clear_ff) begin
         color_in = COLOR_CLEAR;
      end else begin
         color_in = COLOR_DIM;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
   end

   assign rsp_valid      = vld_ff[VLD_STAGES-1];
   assign rsp_argb_color = color_ff;

endmodule
